// File: hdl/positional_list_engine_macros.svh
// ----------------------------------------------------------------------------
// positional list engine assertion macros
// concurrent checks on clk, disabled while rst_n is low; empty in synthesis
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define PLE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional list engine check failed");
// antecedent implies consequent in the next cycle
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional list engine check failed");
`else
`define PLE_ASSERT_SAME(lbl, ante, cons)
`define PLE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// shared sizes, request and result types, codes and sequencer states
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;
  localparam int CMD_W    = 3;
  localparam int ST_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_READ      = 3'd6
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] element;
    logic                    last;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_RD_ISSUE,
    S_RD_OUT,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INS,
    ACT_DEL,
    ACT_POP,
    ACT_READ
  } act_t;

endpackage

// File: hdl/ple_store.sv
// ----------------------------------------------------------------------------
// ple_store
// list value memory: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ple_store (
  input  logic                    clk,
  input  ple_pkg::mem_req_t       mem_req,
  output logic [ple_pkg::VAL_W-1:0] rdata
);
  import ple_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rdata_r <= mem[mem_req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ple_seq.sv
// ----------------------------------------------------------------------------
// ple_seq
// command sequencer with one shared index step unit for shifts and read-out
// ----------------------------------------------------------------------------
`include "positional_list_engine_macros.svh"

module ple_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ple_pkg::in_t            in_data,
  output logic                    res_valid,
  input  logic                    res_ready,
  output ple_pkg::out_t           res,
  output ple_pkg::mem_req_t       mem_req,
  input  logic [ple_pkg::VAL_W-1:0] rdata
);
  import ple_pkg::*;

  state_t           state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [ST_W-1:0]  status_r, status_nxt;

  logic             full, empty;
  logic [ST_W-1:0]  dec_st;
  act_t             dec_act;
  logic [IDX_W-1:0] dec_idx;
  logic             step_down;
  logic [CNT_W-1:0] step_sum;

  assign full  = (cnt_r == CNT_W'(CAPACITY));
  assign empty = (cnt_r == '0);

  // command checks, in the order the list rules apply
  always_comb begin
    logic [POS_W-1:0] pe;
    pe      = (pos_r == '0) ? POS_W'(1) : pos_r;
    dec_st  = ST_OK;
    dec_act = ACT_NONE;
    dec_idx = '0;
    case (cmd_r)
      CMD_INS_FRONT: begin
        if (full) dec_st = ST_FULL;
        else      dec_act = ACT_INS;
      end
      CMD_INS_END: begin
        if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_act = ACT_INS;
          dec_idx = IDX_W'(cnt_r);
        end
      end
      CMD_INS_POS: begin
        if (pos_r == '0) begin
          dec_st = ST_BADPOS;
        end else if (empty) begin
          dec_act = ACT_INS;
        end else if (pos_r > POS_W'(cnt_r)) begin
          dec_st = ST_BADPOS;
        end else if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_act = ACT_INS;
          dec_idx = IDX_W'(pos_r - POS_W'(1));
        end
      end
      CMD_DEL_FRONT: begin
        if (empty) dec_st = ST_EMPTY;
        else       dec_act = ACT_DEL;
      end
      CMD_DEL_END: begin
        if (empty) dec_st = ST_EMPTY;
        else       dec_act = ACT_POP;
      end
      CMD_DEL_POS: begin
        if (empty) begin
          dec_st = ST_EMPTY;
        end else if (pe > POS_W'(cnt_r)) begin
          dec_st = ST_BADPOS;
        end else begin
          dec_act = ACT_DEL;
          dec_idx = IDX_W'(pe - POS_W'(1));
        end
      end
      CMD_READ: begin
        if (empty) dec_st = ST_EMPTY;
        else       dec_act = ACT_READ;
      end
      default: dec_st = ST_BADPOS;
    endcase
  end

  // shared index step unit: down while opening a gap, up otherwise
  assign step_down = (state_r == S_INS_RD) || (state_r == S_INS_WR);
  assign step_sum  = CNT_W'(ptr_r) + (step_down ? {CNT_W{1'b1}} : CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        case (dec_act)
          ACT_INS:  state_nxt = S_INS_RD;
          ACT_DEL:  state_nxt = S_DEL_RD;
          ACT_READ: state_nxt = S_RD_ISSUE;
          default:  state_nxt = S_RESP;
        endcase
      end
      S_INS_RD:   state_nxt = (ptr_r == idx_r) ? S_RESP : S_INS_WR;
      S_INS_WR:   state_nxt = S_INS_RD;
      S_DEL_RD:   state_nxt = (step_sum == cnt_r) ? S_RESP : S_DEL_WR;
      S_DEL_WR:   state_nxt = S_DEL_RD;
      S_RD_ISSUE: state_nxt = S_RD_OUT;
      S_RD_OUT: begin
        if (res_ready) state_nxt = (step_sum == cnt_r) ? S_IDLE : S_RD_ISSUE;
      end
      S_RESP: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory requests and results
  always_comb begin
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    in_stall   = 1'b1;
    res_valid  = 1'b0;
    res        = '0;
    mem_req    = '0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_nxt = in_data.command;
          val_nxt = in_data.value;
          pos_nxt = in_data.position;
        end
      end
      S_DECIDE: begin
        status_nxt = dec_st;
        idx_nxt    = dec_idx;
        case (dec_act)
          ACT_INS:  ptr_nxt = IDX_W'(cnt_r);
          ACT_DEL:  ptr_nxt = dec_idx;
          ACT_READ: ptr_nxt = '0;
          ACT_POP:  cnt_nxt = cnt_r - CNT_W'(1);
          default:  ptr_nxt = ptr_r;
        endcase
      end
      S_INS_RD: begin
        if (ptr_r == idx_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = idx_r;
          mem_req.wdata = val_r;
          cnt_nxt       = cnt_r + CNT_W'(1);
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = step_sum[IDX_W-1:0];
        end
      end
      S_INS_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = rdata;
        ptr_nxt       = step_sum[IDX_W-1:0];
      end
      S_DEL_RD: begin
        if (step_sum == cnt_r) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = step_sum[IDX_W-1:0];
        end
      end
      S_DEL_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = rdata;
        ptr_nxt       = step_sum[IDX_W-1:0];
      end
      S_RD_ISSUE: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = ptr_r;
      end
      S_RD_OUT: begin
        res_valid   = 1'b1;
        res.status  = ST_OK;
        res.element = rdata;
        res.last    = (step_sum == cnt_r);
        if (res_ready) ptr_nxt = step_sum[IDX_W-1:0];
      end
      S_RESP: begin
        res_valid   = 1'b1;
        res.status  = status_r;
        res.element = '0;
        res.last    = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    ptr_r    <= ptr_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
  end

  `PLE_ASSERT_SAME(a_cnt_range, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  `PLE_ASSERT_SAME(a_ins_room, step_down, (cnt_r < CNT_W'(CAPACITY)) && (ptr_r >= idx_r))
  `PLE_ASSERT_SAME(a_walk_bound, (state_r == S_DEL_WR) || (state_r == S_RD_OUT), CNT_W'(ptr_r) < cnt_r)
  `PLE_ASSERT_NEXT(a_read_done, (state_r == S_RD_OUT) && res_ready && res.last, state_r == S_IDLE)

endmodule

// File: hdl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed values with positional access
// insert: each element behind the slot moves up by a read and a write, then the
// value is written; delete moves those elements down; delete end and errors go
// straight to status; read-out: one element at a time, single registered read port
// one command at a time; synchronous active-low reset empties the list
// next command taken the cycle after the last result reaches the output register
// ----------------------------------------------------------------------------
`include "positional_list_engine_macros.svh"

module positional_list_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ple_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ple_pkg::out_t   out_data
);
  import ple_pkg::*;

  // sequencer to output register
  logic       res_valid;
  logic       res_ready;
  out_t       res;

  // sequencer to list memory
  mem_req_t         mem_req;
  logic [VAL_W-1:0] rdata;

  // output register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  ple_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .rdata     (rdata)
  );

  ple_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  // the slot frees up in the same cycle the downstream side takes the request
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset, it is qualified by out_valid_r
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a request taken from the sequencer always lands in the output slot
  `PLE_ASSERT_NEXT(a_res_lands, res_valid && res_ready, out_valid_r && (out_data_r == $past(res)))
  // no new command while a result is still owed downstream
  `PLE_ASSERT_SAME(a_busy_stall, res_valid, in_stall)

endmodule
